FILE: design/stmf_pkg.sv
package stmf_pkg;

  // block geometry
  localparam int MaxSamples  = 64;
  localparam int IdxW        = $clog2(MaxSamples);
  localparam int NW          = $clog2(MaxSamples + 1);
  localparam int DataW       = 16;
  localparam int SumW        = 22;
  localparam int DivCntW     = $clog2(SumW);
  localparam int CountRegW   = 7;
  localparam int WordCntW    = 8;
  localparam int TrimDivisor = 5;
  localparam int ProdW       = NW + 8;

  // configuration register indexes
  localparam logic CfgIdxCount  = 1'b0;
  localparam logic CfgIdxSelect = 1'b1;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_LOAD,
    S_DRAIN,
    S_START,
    S_DIVIDE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t             mode;
    logic [DataW-1:0]       key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   vld;
    logic [DataW-1:0]       val;
  } cell_data_t;

  // clamp the programmed count to 1..MaxSamples
  function automatic logic [NW-1:0] eff_count(input logic [CountRegW-1:0] cnt);
    logic [NW-1:0] n;
    if (cnt == '0) begin
      n = NW'(1);
    end else if (int'(cnt) > MaxSamples) begin
      n = NW'(MaxSamples);
    end else begin
      n = NW'(cnt);
    end
    return n;
  endfunction

  // samples dropped at each end: n/5 by reciprocal (205/1024), none for n <= 5
  function automatic logic [NW-1:0] trim_cut(input logic [NW-1:0] n);
    logic [ProdW-1:0] prod;
    logic [NW-1:0]    cut;
    prod = ProdW'(n) * ProdW'(205);
    if (int'(n) > TrimDivisor) begin
      cut = NW'(prod[ProdW-1:10]);
    end else begin
      cut = '0;
    end
    return cut;
  endfunction

endpackage

FILE: design/stmf_cell.sv
module stmf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stmf_pkg::cell_ctrl_t ctrl_i,
  input  stmf_pkg::cell_data_t prev_i,
  input  logic                prev_le_i,
  input  stmf_pkg::cell_data_t next_i,
  output stmf_pkg::cell_data_t own_o,
  output logic                le_o
);

  logic                         vld_r;
  logic                         vld_nxt;
  logic [stmf_pkg::DataW-1:0]   val_r;
  logic [stmf_pkg::DataW-1:0]   val_nxt;

  // this cell holds a value not above the broadcast key
  assign le_o      = vld_r && (val_r <= ctrl_i.key);
  assign own_o.vld = vld_r;
  assign own_o.val = val_r;

  // keep, take the key, take the left neighbor, or shift from the right
  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    case (ctrl_i.mode)
      stmf_pkg::CELL_INSERT: begin
        if (!le_o) begin
          if (prev_le_i) begin
            vld_nxt = 1'b1;
            val_nxt = ctrl_i.key;
          end else begin
            vld_nxt = prev_i.vld;
            val_nxt = prev_i.val;
          end
        end
      end
      stmf_pkg::CELL_SHIFT: begin
        vld_nxt = next_i.vld;
        val_nxt = next_i.val;
      end
      default: begin
        vld_nxt = vld_r;
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: design/stmf_sort_chain.sv
module stmf_sort_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stmf_pkg::cell_ctrl_t ctrl_i,
  output stmf_pkg::cell_data_t head_o
);

  stmf_pkg::cell_data_t own_w  [stmf_pkg::MaxSamples];
  stmf_pkg::cell_data_t prev_w [stmf_pkg::MaxSamples];
  stmf_pkg::cell_data_t next_w [stmf_pkg::MaxSamples];
  logic                 le_w      [stmf_pkg::MaxSamples];
  logic                 prev_le_w [stmf_pkg::MaxSamples];

  // row of sorting cells, smallest value at cell 0
  for (genvar i = 0; i < stmf_pkg::MaxSamples; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i]    = '0;
      assign prev_le_w[i] = 1'b1;
    end else begin : g_mid
      assign prev_w[i]    = own_w[i-1];
      assign prev_le_w[i] = le_w[i-1];
    end

    if (i == stmf_pkg::MaxSamples - 1) begin : g_last
      assign next_w[i] = '0;
    end else begin : g_inner
      assign next_w[i] = own_w[i+1];
    end

    stmf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl_i),
      .prev_i    (prev_w[i]),
      .prev_le_i (prev_le_w[i]),
      .next_i    (next_w[i]),
      .own_o     (own_w[i]),
      .le_o      (le_w[i])
    );
  end

  assign head_o = own_w[0];

endmodule

FILE: design/stmf_div.sv
module stmf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [stmf_pkg::SumW-1:0]  dividend_i,
  input  logic [stmf_pkg::NW-1:0]    divisor_i,
  output logic                       busy_o,
  output logic [stmf_pkg::SumW-1:0]  quotient_o
);

  logic                          busy_r;
  logic                          busy_nxt;
  logic [stmf_pkg::DivCntW-1:0]  cnt_r;
  logic [stmf_pkg::DivCntW-1:0]  cnt_nxt;
  logic [stmf_pkg::NW-1:0]       rem_r;
  logic [stmf_pkg::NW-1:0]       rem_nxt;
  logic [stmf_pkg::SumW-1:0]     dq_r;
  logic [stmf_pkg::SumW-1:0]     dq_nxt;
  logic [stmf_pkg::NW-1:0]       dvs_r;
  logic [stmf_pkg::NW-1:0]       dvs_nxt;
  logic [stmf_pkg::NW:0]         trial;
  logic [stmf_pkg::NW:0]         diff;
  logic                          ge;

  // one restoring step: quotient bits shift in where dividend bits leave
  assign trial = {rem_r, dq_r[stmf_pkg::SumW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = stmf_pkg::DivCntW'(stmf_pkg::SumW - 1);
      rem_nxt  = '0;
      dq_nxt   = dividend_i;
      dvs_nxt  = divisor_i;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[stmf_pkg::NW-1:0] : trial[stmf_pkg::NW-1:0];
      dq_nxt  = {dq_r[stmf_pkg::SumW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy_o     = busy_r;
  assign quotient_o = dq_r;

endmodule

FILE: design/sorted_trimmed_mean_filter.sv
// Trimmed-mean filter for one channel of an interleaved two-channel ADC buffer.
// Buffer words are taken one per cycle while the input is not stalled; the even
// (channel_select 0) or odd (channel_select 1) words of each block of 2*N words
// go into a 64-entry sample memory, N being sample_count clamped to 1..64. The
// word that closes a block starts the sort: the N samples are read out of the
// memory one per cycle into a row of insertion cells, shifted back out smallest
// first while the middle ones are summed, and the sum is divided by the number
// kept in a bit-serial divider. N/5 samples are dropped at each end, none when N
// is 5 or less, and the mean is truncated. The input is stalled from the closing
// word until the result enters the output register, and stays stalled while an
// earlier result still waits there. A result stays in the output register until
// taken; the next block's words are accepted meanwhile. Store entries of a
// channel position never written hold no defined value.
// Configuration is meant to be written while no sort is running; a count
// lowered mid-block below the position reached closes the block at the next word.
module sorted_trimmed_mean_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [stmf_pkg::DataW-1:0]           in_buffer_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stmf_pkg::DataW-1:0]           out_trimmed_mean,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [stmf_pkg::CountRegW-1:0]       cfg_data
);

  stmf_pkg::state_t                 state_r;
  stmf_pkg::state_t                 state_nxt;
  logic [stmf_pkg::CountRegW-1:0]   sample_count_r;
  logic                             channel_select_r;
  logic [stmf_pkg::WordCntW-1:0]    word_counter_r;
  logic [stmf_pkg::WordCntW-1:0]    word_counter_nxt;
  logic [stmf_pkg::NW-1:0]          n_blk_r;
  logic [stmf_pkg::NW-1:0]          n_blk_nxt;
  logic [stmf_pkg::NW-1:0]          cut_r;
  logic [stmf_pkg::NW-1:0]          cut_nxt;
  logic [stmf_pkg::NW-1:0]          kept_r;
  logic [stmf_pkg::NW-1:0]          kept_nxt;
  logic [stmf_pkg::NW-1:0]          ld_cnt_r;
  logic [stmf_pkg::NW-1:0]          ld_cnt_nxt;
  logic [stmf_pkg::NW-1:0]          drain_cnt_r;
  logic [stmf_pkg::NW-1:0]          drain_cnt_nxt;
  logic                             rd_pend_r;
  logic                             rd_pend_nxt;
  logic [stmf_pkg::DataW-1:0]       rd_data_r;
  logic [stmf_pkg::SumW-1:0]        sum_r;
  logic [stmf_pkg::SumW-1:0]        sum_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [stmf_pkg::DataW-1:0]       out_data_r;
  logic [stmf_pkg::DataW-1:0]       store_mem [stmf_pkg::MaxSamples];

  logic                             in_acc;
  logic                             out_acc;
  logic                             out_load;
  logic                             close;
  logic                             wr_en;
  logic                             rd_en;
  logic [stmf_pkg::IdxW-1:0]        rd_addr;
  logic [stmf_pkg::WordCntW-2:0]    pos_idx;
  logic [stmf_pkg::NW-1:0]          n_cur;
  logic [stmf_pkg::NW-1:0]          cut_cur;
  logic                             div_start;
  logic                             div_busy;
  logic [stmf_pkg::SumW-1:0]        div_quot;
  stmf_pkg::cell_ctrl_t             cell_ctrl;
  stmf_pkg::cell_data_t             head;

  // handshakes
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_trimmed_mean = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r   <= stmf_pkg::CountRegW'(10);
      channel_select_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stmf_pkg::CfgIdxCount:  sample_count_r   <= cfg_data;
        stmf_pkg::CfgIdxSelect: channel_select_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // position within the block, store write and block close
  assign n_cur   = stmf_pkg::eff_count(sample_count_r);
  assign cut_cur = stmf_pkg::trim_cut(n_cur);
  assign pos_idx = word_counter_r[stmf_pkg::WordCntW-1:1];
  assign wr_en   = in_acc && (word_counter_r[0] == channel_select_r) &&
                   ((stmf_pkg::WordCntW + 1)'(pos_idx) < (stmf_pkg::WordCntW + 1)'(n_cur));
  assign close   = ((stmf_pkg::WordCntW + 1)'(word_counter_r) + 1'b1) >=
                   ((stmf_pkg::WordCntW + 1)'(n_cur) << 1);

  always_comb begin
    word_counter_nxt = word_counter_r;
    if (in_acc) begin
      word_counter_nxt = close ? '0 : word_counter_r + 1'b1;
    end
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[pos_idx[stmf_pkg::IdxW-1:0]] <= in_buffer_word;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // sequencer: collect, load cells, drain and sum, divide, hand over result
  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    n_blk_nxt     = n_blk_r;
    cut_nxt       = cut_r;
    kept_nxt      = kept_r;
    ld_cnt_nxt    = ld_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ld_cnt_r[stmf_pkg::IdxW-1:0];
    sum_nxt       = sum_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    cell_ctrl.mode = stmf_pkg::CELL_HOLD;
    cell_ctrl.key  = rd_data_r;
    case (state_r)
      stmf_pkg::S_COLLECT: begin
        in_stall = 1'b0;
        if (in_acc && close) begin
          n_blk_nxt  = n_cur;
          cut_nxt    = cut_cur;
          kept_nxt   = n_cur - {cut_cur[stmf_pkg::NW-2:0], 1'b0};
          ld_cnt_nxt = '0;
          state_nxt  = stmf_pkg::S_LOAD;
        end
      end
      stmf_pkg::S_LOAD: begin
        rd_en       = ld_cnt_r < n_blk_r;
        rd_pend_nxt = rd_en;
        if (rd_en) begin
          ld_cnt_nxt = ld_cnt_r + 1'b1;
        end
        if (rd_pend_r) begin
          cell_ctrl.mode = stmf_pkg::CELL_INSERT;
        end
        if (!rd_en && !rd_pend_r) begin
          drain_cnt_nxt = '0;
          sum_nxt       = '0;
          state_nxt     = stmf_pkg::S_DRAIN;
        end
      end
      stmf_pkg::S_DRAIN: begin
        cell_ctrl.mode = stmf_pkg::CELL_SHIFT;
        if ((drain_cnt_r >= cut_r) && (drain_cnt_r < (n_blk_r - cut_r))) begin
          sum_nxt = sum_r + stmf_pkg::SumW'(head.val);
        end
        drain_cnt_nxt = drain_cnt_r + 1'b1;
        if (drain_cnt_r == (n_blk_r - 1'b1)) begin
          state_nxt = stmf_pkg::S_START;
        end
      end
      stmf_pkg::S_START: begin
        div_start = 1'b1;
        state_nxt = stmf_pkg::S_DIVIDE;
      end
      stmf_pkg::S_DIVIDE: begin
        if (!div_busy) begin
          state_nxt = stmf_pkg::S_RESULT;
        end
      end
      stmf_pkg::S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = stmf_pkg::S_COLLECT;
        end
      end
      default: begin
        state_nxt = stmf_pkg::S_COLLECT;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= stmf_pkg::S_COLLECT;
      word_counter_r <= '0;
      n_blk_r        <= '0;
      cut_r          <= '0;
      kept_r         <= '0;
      ld_cnt_r       <= '0;
      drain_cnt_r    <= '0;
      rd_pend_r      <= 1'b0;
      sum_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      word_counter_r <= word_counter_nxt;
      n_blk_r        <= n_blk_nxt;
      cut_r          <= cut_nxt;
      kept_r         <= kept_nxt;
      ld_cnt_r       <= ld_cnt_nxt;
      drain_cnt_r    <= drain_cnt_nxt;
      rd_pend_r      <= rd_pend_nxt;
      sum_r          <= sum_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= div_quot[stmf_pkg::DataW-1:0];
    end
  end

  stmf_sort_chain u_sort_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (cell_ctrl),
    .head_o (head)
  );

  stmf_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (sum_r),
    .divisor_i  (kept_r),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // every drained position must carry a sorted sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stmf_pkg::S_DRAIN) |-> head.vld)
    else $error("cell row ran dry while draining");

  // divisor is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stmf_pkg::S_DIVIDE) |-> (kept_r != '0))
    else $error("zero kept samples at divide");

  // the closing word starts the sort
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && close) |=> (state_r == stmf_pkg::S_LOAD))
    else $error("block close did not start the sort");

endmodule

FILE: sim/trimmed_mean_checker.sv
`timescale 1ns / 1ps

module trimmed_mean_checker
  import stmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [DataW-1:0]     in_buffer_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [DataW-1:0]     out_trimmed_mean,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [CountRegW-1:0] cfg_data,
  output int                   mismatch_count,
  output int                   pending_means,
  output int                   means_checked
);

  localparam int CountAtReset = 10;

  // shadow of the block state
  logic [DataW-1:0]     sample_mem [MaxSamples];
  logic [CountRegW-1:0] count_reg;
  logic                 select_reg;
  int unsigned          word_pos;
  logic [DataW-1:0]     mean_queue [$];
  int                   fail_tally;
  int                   checked_tally;

  function automatic int unsigned samples_per_block(input logic [CountRegW-1:0] c);
    int unsigned n;
    n = c;
    if (n < 1) begin
      n = 1;
    end else if (n > MaxSamples) begin
      n = MaxSamples;
    end
    return n;
  endfunction

  // store one buffer word; on the closing word, sort, trim and queue the mean
  task automatic absorb_word(input logic [DataW-1:0] w);
    int unsigned      n, cut, kept, i, j;
    logic [SumW-1:0]  total;
    logic [DataW-1:0] ordered [MaxSamples];
    logic [DataW-1:0] key;
    n = samples_per_block(count_reg);
    if (word_pos[0] == select_reg && (word_pos >> 1) < n) begin
      sample_mem[word_pos >> 1] = w;
    end
    if (word_pos + 1 < 2 * n) begin
      word_pos = word_pos + 1;
    end else begin
      for (i = 0; i < n; i++) begin
        ordered[i] = sample_mem[i];
      end
      // insertion sort, ascending
      for (i = 1; i < n; i++) begin
        key = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j = j - 1;
        end
        ordered[j] = key;
      end
      cut = (n > TrimDivisor) ? n / TrimDivisor : 0;
      total = '0;
      for (i = cut; i < n - cut; i++) begin
        total = total + ordered[i];
      end
      kept = n - 2 * cut;
      mean_queue.push_back(DataW'(total / kept));
      word_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg     = CountRegW'(CountAtReset);
      select_reg    = 1'b0;
      word_pos      = 0;
      fail_tally    = 0;
      checked_tally = 0;
      mean_queue.delete();
      for (int k = 0; k < MaxSamples; k++) begin
        sample_mem[k] = '0;
      end
    end else begin
      // result side first: a mean leaving now was queued at an earlier edge
      if (out_valid && !out_stall) begin
        if (mean_queue.size() == 0) begin
          $display("%0t: trimmed mean %0d arrived with none expected",
                   $time, out_trimmed_mean);
          fail_tally++;
        end else begin
          if (out_trimmed_mean !== mean_queue[0]) begin
            $display("%0t: trimmed mean expected %0d actual %0d",
                     $time, mean_queue[0], out_trimmed_mean);
            fail_tally++;
          end
          checked_tally++;
          void'(mean_queue.pop_front());
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgIdxCount) begin
          count_reg = cfg_data;
        end else begin
          select_reg = cfg_data[0];
        end
      end
      // buffer word requests
      if (in_valid && !in_stall) begin
        absorb_word(in_buffer_word);
      end
    end
    mismatch_count <= fail_tally;
    pending_means  <= mean_queue.size();
    means_checked  <= checked_tally;
  end

endmodule

FILE: sim/tb_sorted_trimmed_mean_filter.sv
`timescale 1ns / 1ps

module tb_sorted_trimmed_mean_filter;
  import stmf_pkg::*;

  localparam int TotalWords   = 1950;
  localparam int SettleCycles = 2 * MaxSamples + 32;
  localparam int CycleLimit   = 1000000;
  localparam int ResetCycles  = 11;

  typedef enum logic [1:0] {
    WORDS_ANY,
    WORDS_LOW,
    WORDS_RAILS,
    WORDS_HIGH
  } word_mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DataW-1:0]     in_buffer_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DataW-1:0]     out_trimmed_mean;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = CfgIdxCount;
  logic [CountRegW-1:0] cfg_data = '0;

  int mismatch_count;
  int pending_means;
  int means_checked;

  // stimulus bookkeeping
  int unsigned block_pos = 0;
  int unsigned block_len = 10;
  int          words_sent = 0;
  int          cfg_writes = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  sorted_trimmed_mean_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_buffer_word   (in_buffer_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trimmed_mean (out_trimmed_mean),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  trimmed_mean_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_buffer_word   (in_buffer_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_trimmed_mean (out_trimmed_mean),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pending_means    (pending_means),
    .means_checked    (means_checked)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d means outstanding", cycle_count,
               pending_means);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure: mostly short bursts, a few long ones
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:64]:  out_stall <= 1'b0;
        [65:93]: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(15, 50);
        end
      endcase
    end
  end

  function automatic int unsigned clamp_count(input logic [CountRegW-1:0] c);
    if (c == '0) begin
      return 1;
    end else if (c > MaxSamples) begin
      return MaxSamples;
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DataW-1:0] next_word(input word_mix_t mix);
    case (mix)
      WORDS_LOW:   return DataW'($urandom_range(0, 15));
      WORDS_RAILS: return $urandom_range(0, 1) ? {DataW{1'b1}} : {DataW{1'b0}};
      WORDS_HIGH:  return {DataW{1'b1}} - DataW'($urandom_range(0, 15));
      default:     return DataW'($urandom);
    endcase
  endfunction

  // one buffer word request, with an optional gap ahead of it
  task automatic send_word(input logic [DataW-1:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_buffer_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    block_pos = (block_pos + 1 >= 2 * block_len) ? 0 : block_pos + 1;
  endtask

  // send words until the current block closes
  task automatic close_block(input word_mix_t mix);
    do begin
      send_word(next_word(mix));
    end while (block_pos != 0);
  endtask

  // drop valid and wait until every mean is out and the sorter is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CountRegW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIdxCount) begin
      block_len = clamp_count(data);
    end
    cfg_writes++;
  endtask

  initial begin
    int          phase;
    int unsigned r, blocks;
    word_mix_t   mix;
    logic [CountRegW-1:0] new_count;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count of zero acts as one sample per block
    cfg_write(CfgIdxCount, '0);
    cfg_write(CfgIdxSelect, CountRegW'(0));
    cfg_valid <= 1'b0;
    send_word(16'hFFFF);
    send_word(16'h1234);

    // odd channel, single sample
    settle();
    cfg_write(CfgIdxCount, CountRegW'(1));
    cfg_write(CfgIdxSelect, CountRegW'(1));
    cfg_valid <= 1'b0;
    send_word(16'hAAAA);
    send_word(16'h0000);

    // six samples: one trimmed at each end, rails and ties
    settle();
    cfg_write(CfgIdxCount, CountRegW'(6));
    cfg_valid <= 1'b0;
    send_word(16'h1111); send_word(16'hFFFF);
    send_word(16'h2222); send_word(16'h0000);
    send_word(16'h3333); send_word(16'h8000);
    send_word(16'h4444); send_word(16'h7FFF);
    send_word(16'h5555); send_word(16'hFFFF);
    send_word(16'h6666); send_word(16'h0001);

    // count lowered mid-block below the position reached: next word closes
    settle();
    cfg_write(CfgIdxCount, CountRegW'(10));
    cfg_write(CfgIdxSelect, CountRegW'(0));
    cfg_valid <= 1'b0;
    repeat (5) send_word(next_word(WORDS_ANY));
    settle();
    cfg_write(CfgIdxCount, CountRegW'(2));
    cfg_valid <= 1'b0;
    send_word(next_word(WORDS_ANY));

    // random phases: new settings, then whole blocks of random content
    phase = 0;
    while (words_sent < TotalWords) begin
      settle();
      quiet = 1'b0;
      r = $urandom_range(0, 99);
      if (phase == 0) begin
        new_count = '1;
      end else if (phase == 1) begin
        new_count = CountRegW'(MaxSamples);
      end else if (r < 4) begin
        new_count = '0;
      end else if (r < 10) begin
        new_count = CountRegW'($urandom_range(MaxSamples, (1 << CountRegW) - 1));
      end else if (r < 22) begin
        new_count = CountRegW'($urandom_range(13, 40));
      end else begin
        new_count = CountRegW'($urandom_range(1, 12));
      end
      cfg_write(CfgIdxCount, new_count);
      // channel only changes on a block boundary so no sample goes unwritten
      if (block_pos == 0 && $urandom_range(0, 2) != 0) begin
        cfg_write(CfgIdxSelect, CountRegW'($urandom));
      end
      cfg_valid <= 1'b0;

      quiet  = ($urandom_range(0, 5) == 0);
      mix    = word_mix_t'($urandom_range(0, 3));
      blocks = (block_len > 20) ? 1 : $urandom_range(1, 4);
      repeat (blocks) close_block(mix);
      // sometimes stop partway so the next count lands mid-block
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2 * block_len - 1)) send_word(next_word(mix));
      end
      phase++;
    end

    // drain
    quiet = 1'b0;
    settle();
    $display("sent %0d buffer words, checked %0d block means, %0d register writes",
             words_sent, means_checked, cfg_writes);
    $display("counts zero through 127 with saturation, both channels, mid-block count changes");
    if (mismatch_count == 0 && pending_means == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d means never produced", mismatch_count, pending_means);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
